// ===== design/rtt_pkg.sv =====
// Package for the range top-two tree: widths, node type, merge function.
`default_nettype none
package rtt_pkg;
   localparam int LEAVES    = 1024;
   localparam int LVL       = $clog2(LEAVES);
   localparam int IDX_W     = 10;
   localparam int VAL_W     = 31;
   localparam int PROD_W    = 62;
   localparam int NODE_ADR_W = LVL + 1;
   localparam int NODES     = 2 * LEAVES;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic [VAL_W-1:0] top;
      logic [VAL_W-1:0] second;
      logic [1:0]       n;
   } node_type;

   typedef struct packed {
      logic             func;
      logic [IDX_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] range_low;
      logic [IDX_W-1:0] range_high;
   } item_type;

   // merge two top-two pairs; duplicates count separately
   function automatic node_type pair_merge(input node_type a, input node_type b);
      node_type r;
      r = '0;
      if (a.n == 2'd0) begin
         r = b;
      end else if (b.n == 2'd0) begin
         r = a;
      end else if (a.top >= b.top) begin
         r.top = a.top;
         r.n = 2'd2;
         if (a.n == 2'd2 && a.second > b.top) r.second = a.second;
         else r.second = b.top;
      end else begin
         r.top = b.top;
         r.n = 2'd2;
         if (b.n == 2'd2 && b.second >= a.top) r.second = b.second;
         else r.second = a.top;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== design/rtt_front.sv =====
// Front end: accepts words, clips ranges and queues them for the engine.
`default_nettype none
module rtt_front import rtt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          q_valid,
   input  wire logic     q_ready,
   output item_type      q_item
);
   localparam int QD = 2;
   item_type   mem_ff [QD];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push, pop;

   // classify: empty queries become range_high < range_low; clip high end
   always_comb begin
      cls = in_item;
      if (in_item.func == FUNC_QUERY) begin
         if (32'(in_item.range_high) >= LEAVES)
            cls.range_high = IDX_W'(LEAVES - 1);
         if (32'(in_item.range_low) >= LEAVES) begin
            cls.range_low  = IDX_W'(1);
            cls.range_high = '0;
         end
      end
   end

   assign in_ready = (cnt_ff != 2'(QD));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= cls;
   end
endmodule
`default_nettype wire

// ===== design/rtt_engine.sv =====
// Back end: walks the node memory for writes and range queries.
`default_nettype none
module rtt_engine import rtt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   output logic          q_ready,
   input  wire item_type q_item,
   output logic          res_valid,
   input  wire logic     res_ready,
   output node_type      res_node
);
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_WLEAF = 4'd2,
      S_WRD = 4'd3, S_WRD2 = 4'd4, S_WWAIT = 4'd5, S_WUP = 4'd6,
      S_QSTEP = 4'd7, S_QRD = 4'd8, S_QWAIT = 4'd9, S_DONE = 4'd10;

   // nodes are 1-based heap order, leaves at LEAVES..2*LEAVES-1
   node_type mem [NODES];
   logic [NODE_ADR_W-1:0] raddr;
   node_type rdata_ff;
   logic                  we;
   logic [NODE_ADR_W-1:0] waddr;
   node_type              wdata;

   logic [3:0]            st_ff, st_in;
   logic [NODE_ADR_W-1:0] k_ff, k_in;      // write: current node
   logic [NODE_ADR_W:0]   l_ff, l_in, r_ff, r_in; // query cursors, half open
   node_type              acc_ff, acc_in, lft_ff, lft_in;
   logic                  side_ff, side_in;   // query: which read pending
   logic [NODE_ADR_W:0]   clr_ff, clr_in;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign q_ready   = (st_ff == S_IDLE);
   assign res_valid = (st_ff == S_DONE);
   assign res_node  = acc_ff;

   always_comb begin
      st_in = st_ff; k_in = k_ff; l_in = l_ff; r_in = r_ff;
      acc_in = acc_ff; lft_in = lft_ff; side_in = side_ff;
      clr_in = clr_ff;
      raddr = k_ff; we = 1'b0; waddr = k_ff; wdata = '0;
      case (st_ff)
         // fill nodes after reset: leaves n=1, inner n=2
         S_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff[NODE_ADR_W-1:0];
            wdata.n = clr_ff[NODE_ADR_W-1] ? 2'd1 : 2'd2;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (NODE_ADR_W+1)'(NODES - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            acc_in = '0;
            if (q_valid) begin
               if (q_item.func == FUNC_WRITE) begin
                  k_in = NODE_ADR_W'(LEAVES) + NODE_ADR_W'(q_item.position);
                  lft_in = '0;
                  lft_in.top = q_item.value;
                  lft_in.n = 2'd1;
                  st_in = (32'(q_item.position) < LEAVES) ? S_WLEAF : S_DONE;
               end else if (q_item.range_high < q_item.range_low) begin
                  st_in = S_DONE;
               end else begin
                  l_in = (NODE_ADR_W+1)'(LEAVES) + (NODE_ADR_W+1)'(q_item.range_low);
                  r_in = (NODE_ADR_W+1)'(LEAVES) + (NODE_ADR_W+1)'(q_item.range_high)
                       + 1'b1;
                  st_in = S_QSTEP;
               end
            end
         end
         S_WLEAF: begin
            we = 1'b1; wdata = lft_ff;
            if (k_ff == NODE_ADR_W'(1)) st_in = S_DONE;
            else st_in = S_WRD;
         end
         // read sibling of k, then parent = merge
         S_WRD: begin
            raddr = k_ff ^ NODE_ADR_W'(1);
            st_in = S_WRD2;
         end
         S_WRD2: st_in = S_WWAIT;
         S_WWAIT: begin
            raddr = k_ff ^ NODE_ADR_W'(1);
            st_in = S_WUP;
         end
         S_WUP: begin
            k_in = k_ff >> 1;
            lft_in = pair_merge(lft_ff, rdata_ff);
            we = 1'b1; waddr = k_ff >> 1; wdata = pair_merge(lft_ff, rdata_ff);
            if ((k_ff >> 1) == NODE_ADR_W'(1)) st_in = S_DONE;
            else st_in = S_WRD;
         end
         // bottom-up query: take node l when l is odd and node r-1 when r is odd
         S_QSTEP: begin
            if (l_ff >= r_ff) begin
               st_in = S_DONE;
            end else if (l_ff[0]) begin
               raddr = l_ff[NODE_ADR_W-1:0]; side_in = 1'b0; st_in = S_QRD;
            end else if (r_ff[0]) begin
               raddr = NODE_ADR_W'(r_ff - 1'b1); side_in = 1'b1; st_in = S_QRD;
            end else begin
               l_in = l_ff >> 1; r_in = r_ff >> 1;
            end
         end
         S_QRD: begin
            raddr = side_ff ? NODE_ADR_W'(r_ff - 1'b1) : l_ff[NODE_ADR_W-1:0];
            st_in = S_QWAIT;
         end
         S_QWAIT: begin
            acc_in = pair_merge(acc_ff, rdata_ff);
            if (side_ff) r_in = r_ff - 1'b1;
            else l_in = l_ff + 1'b1;
            st_in = S_QSTEP;
         end
         S_DONE: begin
            if (res_ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= (NODE_ADR_W+1)'(1);
      end else begin
         st_ff <= st_in; clr_ff <= clr_in;
      end
      k_ff <= k_in; l_ff <= l_in; r_ff <= r_in; acc_ff <= acc_in;
      lft_ff <= lft_in; side_ff <= side_in;
   end
endmodule
`default_nettype wire

// ===== design/rtt_out.sv =====
// Output stage: multiplies the pair and holds the result word.
`default_nettype none
module rtt_out import rtt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     res_valid,
   output logic          res_ready,
   input  wire node_type res_node,
   output logic          o_valid,
   input  wire logic     o_ready,
   output node_type      o_node,
   output logic [PROD_W-1:0] o_prod
);
   logic     s1_ff, s1_in, v_ff, v_in;
   node_type n1_ff, n_ff;
   logic [PROD_W-1:0] prod_ff;

   assign res_ready = !s1_ff && !v_ff;
   assign o_valid = v_ff;
   assign o_node  = n_ff;
   assign o_prod  = prod_ff;

   always_comb begin
      s1_in = s1_ff; v_in = v_ff;
      if (res_valid && res_ready) s1_in = 1'b1;
      if (s1_ff) begin s1_in = 1'b0; v_in = 1'b1; end
      if (v_ff && o_ready) v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; v_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in; v_ff <= v_in;
      end
      if (res_valid && res_ready) begin
         n1_ff <= res_node;
         if (res_node.n != 2'd2) n1_ff.second <= '0;
         if (res_node.n == 2'd0) n1_ff.top <= '0;
      end
      if (s1_ff) begin
         n_ff <= n1_ff;
         prod_ff <= PROD_W'(n1_ff.top) * PROD_W'(n1_ff.second);
      end
   end
endmodule
`default_nettype wire

// ===== design/range_top_two_product_tree.sv =====
// Top level of the range top-two tree.
// channel | dir | tdata fields (low bit up)
// req     | in  | func, position, value, range_low, range_high (62b -> 64)
// rsp     | out | top_value, runner_up, present_count, pair_product (126b -> 128)
// After reset a clearing pass fills the node memory; no word is processed then.
// A write reads the sibling node (WRD, WRD2, WWAIT) and writes the merge into the
// parent (WUP), level by level up to the root. A query reads and merges each node
// taken (QSTEP, QRD, QWAIT) and steps up a level in QSTEP. The front queue and the
// product stage add registers. One item is worked at a time; rsp stalls hold the engine.
`default_nettype none
module range_top_two_product_tree import rtt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,  // func, position, value, range_low, range_high
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata   // top_value, runner_up, present_count, pair_product
);
   item_type it, q_item;
   logic q_valid, q_ready, res_valid, res_ready;
   node_type res_node, o_node;
   logic [PROD_W-1:0] o_prod;

   assign it.func       = req_tdata[0];
   assign it.position   = req_tdata[10:1];
   assign it.value      = req_tdata[41:11];
   assign it.range_low  = req_tdata[51:42];
   assign it.range_high = req_tdata[61:52];

   rtt_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(it), .q_valid, .q_ready, .q_item);
   rtt_engine u_engine (.clock, .reset, .q_valid, .q_ready, .q_item,
      .res_valid, .res_ready, .res_node);
   rtt_out u_out (.clock, .reset, .res_valid, .res_ready, .res_node,
      .o_valid(rsp_tvalid), .o_ready(rsp_tready), .o_node, .o_prod);

   assign rsp_tdata = {2'b00, o_prod, o_node.n, o_node.second, o_node.top};
endmodule
`default_nettype wire

// ===== design/rtt_checker.sv =====
// Port-level checker for the range top-two tree, bound to the top level.
`default_nettype none
module rtt_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [127:0] rsp_tdata
);
   // held response word stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");
   // count never 3
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:62] != 2'd3)
      else $error("bad present_count");
   // product zero unless two present
   a_prod: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[63:62] != 2'd2 |-> rsp_tdata[125:64] == '0)
      else $error("product without pair");
   // runner-up not above top
   a_ord: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[61:31] <= rsp_tdata[30:0])
      else $error("runner_up above top");
   // nothing shown right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("activity after reset");
endmodule

bind range_top_two_product_tree rtt_checker u_rtt_checker (.*);
`default_nettype wire

// ===== tb/range_top_two_checker.sv =====
// Checker for the range top-two tree: watches both channels, predicts, compares.
`default_nettype none
module range_top_two_checker import rtt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [63:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PROD_W-1:0] pair_product;
      logic [1:0]        present_count;
      logic [VAL_W-1:0]  runner_up;
      logic [VAL_W-1:0]  top_value;
   } answer_type;

   // flat copy of the leaves; queries scan them directly
   logic [VAL_W-1:0] leaf_value [LEAVES];
   answer_type       answer_queue [$];

   // insert one value into a running top-two pair
   function automatic void top_two_insert(inout node_type r, input logic [VAL_W-1:0] v);
      if (r.n == 2'd0) begin
         r.top = v;
         r.n = 2'd1;
      end else if (v > r.top) begin
         r.second = r.top;
         r.top = v;
         r.n = 2'd2;
      end else if (r.n == 2'd1) begin
         r.second = v;
         r.n = 2'd2;
      end else if (v > r.second) begin
         r.second = v;
      end
   endfunction

   function automatic answer_type range_answer(input logic [IDX_W-1:0] lo,
                                               input logic [IDX_W-1:0] hi);
      answer_type a;
      node_type   r;
      a = '0;
      r = '0;
      if (hi < lo || lo >= LEAVES) return a;
      for (int i = lo; i <= hi && i < LEAVES; i++) top_two_insert(r, leaf_value[i]);
      if (r.n >= 2'd1) a.top_value = r.top;
      if (r.n >= 2'd2) begin
         a.runner_up = r.second;
         a.pair_product = PROD_W'(64'(r.top) * 64'(r.second));
      end
      a.present_count = r.n;
      return a;
   endfunction

   assign pending_count = answer_queue.size();

   always @(posedge clock) begin
      item_type   it;
      answer_type got, want;
      if (reset) begin
         for (int i = 0; i < LEAVES; i++) leaf_value[i] = '0;
         answer_queue.delete();
         fail_count <= 0;
      end else begin
         // predict on each accepted request word
         if (req_tvalid && req_tready) begin
            it = '0;
            it.func       = req_tdata[0];
            it.position   = req_tdata[10:1];
            it.value      = req_tdata[41:11];
            it.range_low  = req_tdata[51:42];
            it.range_high = req_tdata[61:52];
            if (it.func == FUNC_WRITE) begin
               if (it.position < LEAVES) leaf_value[it.position] = it.value;
               answer_queue.push_back('0);
            end else begin
               answer_queue.push_back(range_answer(it.range_low, it.range_high));
            end
         end
         // compare each accepted response word
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[125:0];
            if (answer_queue.size() == 0) begin
               $error("unexpected response word %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (got.top_value !== want.top_value)
                  $error("top_value exp %0d got %0d", want.top_value, got.top_value);
               if (got.runner_up !== want.runner_up)
                  $error("runner_up exp %0d got %0d", want.runner_up, got.runner_up);
               if (got.present_count !== want.present_count)
                  $error("present_count exp %0d got %0d", want.present_count,
                         got.present_count);
               if (got.pair_product !== want.pair_product)
                  $error("pair_product exp %0d got %0d", want.pair_product,
                         got.pair_product);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Stimulus and verdict for the range top-two tree.
`default_nettype none
module testbench import rtt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   int           fail_count;
   int           pending_count;
   int           send_idle_pct;
   int           recv_idle_pct;
   logic         hot_mode;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   range_top_two_product_tree u_dut (.*);

   range_top_two_checker u_check (.*);

   // receiver stalls at random
   always @(posedge clock)
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // send one word; valid stays high into the next word when no gap follows
   task automatic send_word(input logic f, input logic [IDX_W-1:0] p,
                            input logic [VAL_W-1:0] v, input logic [IDX_W-1:0] lo,
                            input logic [IDX_W-1:0] hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, hi, lo, v, p, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_leaf(input logic [IDX_W-1:0] p, input logic [VAL_W-1:0] v);
      send_word(FUNC_WRITE, p, v, IDX_W'($urandom), IDX_W'($urandom));
   endtask

   task automatic query_range(input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
      send_word(FUNC_QUERY, IDX_W'($urandom), VAL_W'($urandom), lo, hi);
   endtask

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(3))
         0:       return VAL_W'($urandom_range(3));
         1:       return {1'b0, 30'h3fff_ffff} + 31'($urandom_range(1));
         2:       return 31'h7fff_ffff - 31'($urandom_range(2));
         default: return VAL_W'($urandom);
      endcase
   endfunction

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [IDX_W-1:0] lo, hi;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset zeros, extremes, duplicates and empty ranges
      query_range(0, 1023);
      query_range(5, 5);
      query_range(9, 3);
      write_leaf(0, 31'h7fff_ffff);
      write_leaf(1023, 31'h7fff_ffff);
      query_range(0, 1023);
      write_leaf(512, 31'h2aaa_aaaa);
      write_leaf(511, 31'h5555_5555);
      query_range(500, 600);
      query_range(511, 511);
      query_range(1023, 1023);
      query_range(1023, 0);
      write_leaf(1023, 0);
      write_leaf(0, 1);
      query_range(0, 0);
      query_range(0, 1);
      write_leaf(700, 31'h7fff_ffff);
      query_range(600, 800);
      query_range(1, 1022);

      // pause until everything has drained
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // random phases: receiver idles most, then sender idles most, then full speed
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 66 : 0;
         recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 28 : 0;
         for (int n = 0; n < 130; n++) begin
            hot_mode = ($urandom_range(3) != 0);
            if ($urandom_range(1)) begin
               write_leaf(hot_mode ? 10'($urandom_range(40)) : 10'($urandom), rand_value());
            end else begin
               lo = hot_mode ? 10'($urandom_range(40)) : 10'($urandom);
               hi = ($urandom_range(9) == 0) ? 10'($urandom) :
                    10'(lo + $urandom_range(hot_mode ? 12 : 300));
               query_range(lo, hi);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
design/rtt_pkg.sv
design/rtt_front.sv
design/rtt_engine.sv
design/rtt_out.sv
design/range_top_two_product_tree.sv
design/rtt_checker.sv
tb/range_top_two_checker.sv
tb/testbench.sv
